### hdl/sha20_pkg.sv
`timescale 1ns / 1ps
// sha20_pkg: shared types, round constants and SHA-256 bit functions for the
// fixed 20-byte hash pipeline. No dependencies.
package sha20_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned MSG_WORDS  = 5;
  localparam int unsigned DIG_WORDS  = 8;
  localparam int unsigned SCHED_LEN  = 16;

  localparam logic [31:0] PAD_MARK = 32'h8000_0000;
  localparam logic [31:0] MSG_BITS = 32'd160;

  // Working variables a..h, index 0 is a.
  typedef logic [DIG_WORDS-1:0][31:0] state_t;
  // Sliding message schedule window, index 0 is the word used this round.
  typedef logic [SCHED_LEN-1:0][31:0] sched_t;

  localparam state_t INIT_H = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [NUM_ROUNDS-1:0][31:0] ROUND_K = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] swap_bytes(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

### hdl/sha256_fixed_20_byte_hash.sv
`timescale 1ns / 1ps
// sha256_fixed_20_byte_hash: top level, 64-cell round pipeline and digest register.
// Depends on sha20_pkg and sha20_round_cell.
//
// Usage
//   Input channel: in_valid / in_stall with msg_word0..msg_word4. Each word
//   carries four message bytes little-endian and is byte-swapped on entry.
//   The block pads the 20-byte message to one SHA-256 block (0x80 marker,
//   zero fill, length 160) and hashes it from the standard initial values.
//   Output channel: out_valid / out_stall with hash_word0..hash_word7, the
//   eight digest words H0..H7, not swapped back. One result per message taken.
//   Path: each item passes the 64 round cells in order and then the output
//   register; the final digest add sits combinationally in front of it.
//   Throughput: one message per cycle while not stalled; a row of 64 round
//   cells each holds one item's working variables and its 16-word schedule
//   window and hands both to the next cell every cycle the row advances.
//   Stall: when a result sits in the output register and out_stall is high,
//   the whole row holds and in_stall goes high. The row moves again in the
//   cycle the result is taken.
//   Reset: synchronous, clears every cell's valid bit and out_valid; items
//   in flight are dropped.
module sha256_fixed_20_byte_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] msg_word0,
  input  logic [31:0] msg_word1,
  input  logic [31:0] msg_word2,
  input  logic [31:0] msg_word3,
  input  logic [31:0] msg_word4,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_word0,
  output logic [31:0] hash_word1,
  output logic [31:0] hash_word2,
  output logic [31:0] hash_word3,
  output logic [31:0] hash_word4,
  output logic [31:0] hash_word5,
  output logic [31:0] hash_word6,
  output logic [31:0] hash_word7
);

  localparam int unsigned NR = sha20_pkg::NUM_ROUNDS;

  logic              en;
  logic              vld   [NR+1];
  sha20_pkg::state_t state [NR+1];
  sha20_pkg::sched_t sched [NR+1];
  sha20_pkg::state_t digest_next;

  // Row advances unless a finished result is held by the receiver.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Padded block: five swapped message words, marker, zeros, bit length.
  always_comb begin
    sched[0]     = '0;
    sched[0][0]  = sha20_pkg::swap_bytes(msg_word0);
    sched[0][1]  = sha20_pkg::swap_bytes(msg_word1);
    sched[0][2]  = sha20_pkg::swap_bytes(msg_word2);
    sched[0][3]  = sha20_pkg::swap_bytes(msg_word3);
    sched[0][4]  = sha20_pkg::swap_bytes(msg_word4);
    sched[0][5]  = sha20_pkg::PAD_MARK;
    sched[0][15] = sha20_pkg::MSG_BITS;
  end

  assign vld[0]   = in_valid;
  assign state[0] = sha20_pkg::INIT_H;

  for (genvar i = 0; i < NR; i++) begin : g_round
    sha20_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_vld    (vld[i]),
      .in_state  (state[i]),
      .in_sched  (sched[i]),
      .k         (sha20_pkg::ROUND_K[i]),
      .out_vld   (vld[i+1]),
      .out_state (state[i+1]),
      .out_sched (sched[i+1])
    );
  end

  // Feed-forward add with the initial hash values.
  always_comb begin
    for (int j = 0; j < sha20_pkg::DIG_WORDS; j++) begin
      digest_next[j] = sha20_pkg::INIT_H[j] + state[NR][j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NR];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash_word0 <= digest_next[0];
      hash_word1 <= digest_next[1];
      hash_word2 <= digest_next[2];
      hash_word3 <= digest_next[3];
      hash_word4 <= digest_next[4];
      hash_word5 <= digest_next[5];
      hash_word6 <= digest_next[6];
      hash_word7 <= digest_next[7];
    end
  end

endmodule

### hdl/sha20_round_cell.sv
`timescale 1ns / 1ps
// sha20_round_cell: one SHA-256 round plus one schedule step, registered.
// Depends on sha20_pkg.
module sha20_round_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  sha20_pkg::state_t in_state,
  input  sha20_pkg::sched_t in_sched,
  input  logic [31:0]       k,
  output logic              out_vld,
  output sha20_pkg::state_t out_state,
  output sha20_pkg::sched_t out_sched
);

  logic [31:0]       t1;
  logic [31:0]       t2;
  logic [31:0]       w_new;
  sha20_pkg::state_t state_next;
  sha20_pkg::sched_t sched_next;

  always_comb begin
    t1 = in_state[7] + sha20_pkg::big_sig1(in_state[4])
       + sha20_pkg::choose(in_state[4], in_state[5], in_state[6]) + k + in_sched[0];
    t2 = sha20_pkg::big_sig0(in_state[0])
       + sha20_pkg::majority(in_state[0], in_state[1], in_state[2]);
    // w[i+16] from the window w[i..i+15]
    w_new = sha20_pkg::small_sig1(in_sched[14]) + in_sched[9]
          + sha20_pkg::small_sig0(in_sched[1]) + in_sched[0];

    state_next[0] = t1 + t2;
    state_next[1] = in_state[0];
    state_next[2] = in_state[1];
    state_next[3] = in_state[2];
    state_next[4] = in_state[3] + t1;
    state_next[5] = in_state[4];
    state_next[6] = in_state[5];
    state_next[7] = in_state[6];

    sched_next = {w_new, in_sched[sha20_pkg::SCHED_LEN-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= state_next;
      out_sched <= sched_next;
    end
  end

endmodule
